// File: sv/isort_pkg.sv
package isort_pkg;

  // capacity of the sorting row
  localparam int unsigned MAX_ITEMS = 32;
  // fill count must hold MAX_ITEMS itself
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int unsigned VAL_W     = 32;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_res;
    logic                    last_res;
    logic                    overflow;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic ins;   // place the incoming value in the row
    logic drop;  // row full, discard the incoming value
    logic pop;   // head of the row has been taken, shift down
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;      // row holds MAX_ITEMS values
    logic last_one;  // exactly one value left
  } sts_t;

endpackage

// File: sv/isort_in_if.sv
interface isort_in_if;
  import isort_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/isort_out_if.sv
interface isort_out_if;
  import isort_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/isort_ctrl.sv
module isort_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  isort_pkg::sts_t    sts_i,
  output isort_pkg::cmd_t    cmd_o
);
  import isort_pkg::*;

  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_DRAIN   = 1'b1;

  logic state_q, state_d;
  logic in_fire, out_fire;

  assign in_ready_o  = (state_q == ST_COLLECT);
  assign out_valid_o = (state_q == ST_DRAIN);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_fire    = out_valid_o & out_ready_i;

  assign cmd_o.ins  = in_fire & ~sts_i.full;
  assign cmd_o.drop = in_fire & sts_i.full;
  assign cmd_o.pop  = out_fire;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_COLLECT: begin
        if (in_fire && in_last_i) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_fire && sts_i.last_one) state_d = ST_COLLECT;
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

  // a closed set always has something to send
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_last_i) |=> (out_valid_o && !in_ready_o))
    else $error("drain entered without output");

  // last beat of a set reopens the input
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && sts_i.last_one) |=> (in_ready_o && !out_valid_o))
    else $error("input not reopened after last beat");

  // never collecting and draining at once
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");

endmodule

// File: sv/isort_dp.sv
module isort_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  isort_pkg::in_item_t   in_data_i,
  input  isort_pkg::cmd_t       cmd_i,
  output isort_pkg::sts_t       sts_o,
  output isort_pkg::out_item_t  out_data_o
);
  import isort_pkg::*;

  logic signed [VAL_W-1:0] store_q [MAX_ITEMS];
  logic signed [VAL_W-1:0] store_d [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]    gt;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    dropped_q, dropped_d;

  // one compare-and-shift cell per row position
  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    assign gt[g] = (CNT_W'(g) < count_q) && (store_q[g] > in_data_i.value);

    always_comb begin
      store_d[g] = store_q[g];
      if (cmd_i.ins) begin
        if (gt[g]) begin
          if (g == 0) begin
            store_d[g] = in_data_i.value;
          end else begin
            store_d[g] = gt[(g == 0) ? 0 : g-1] ? store_q[(g == 0) ? 0 : g-1]
                                                 : in_data_i.value;
          end
        end else if (CNT_W'(g) == count_q) begin
          // first free cell takes the shifted tail or the new value
          if (g == 0) begin
            store_d[g] = in_data_i.value;
          end else begin
            store_d[g] = gt[(g == 0) ? 0 : g-1] ? store_q[(g == 0) ? 0 : g-1]
                                                 : in_data_i.value;
          end
        end
      end else if (cmd_i.pop) begin
        if (g < MAX_ITEMS-1) begin
          store_d[g] = store_q[(g < MAX_ITEMS-1) ? g+1 : g];
        end
      end
    end
  end

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (cmd_i.ins) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.drop) begin
      dropped_d = 1'b1;
    end
    if (cmd_i.pop) begin
      count_d = count_q - CNT_W'(1);
      if (count_q == CNT_W'(1)) dropped_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  assign sts_o.full     = (count_q == CNT_W'(MAX_ITEMS));
  assign sts_o.last_one = (count_q == CNT_W'(1));

  assign out_data_o.value_res = store_q[0];
  assign out_data_o.last_res  = (count_q == CNT_W'(1));
  assign out_data_o.overflow  = dropped_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ITEMS))
    else $error("fill count beyond capacity");

  a_row_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (store_q[0] <= store_q[1]))
    else $error("row head out of order");

  a_set_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop && count_q == CNT_W'(1)) |=> (count_q == '0 && !dropped_q))
    else $error("set not cleared after last beat");

endmodule

// File: sv/insertion_sorter.sv
// insertion sorter
// in_ch takes one signed 32-bit value per beat; a beat with last set closes
// the set. each value drops into a row of compare-and-shift cells, behind
// every stored value equal to or smaller than it, so equal values keep
// their arrival order
// while a set is being collected in_ch.ready is high and one value is taken
// every cycle. the row holds 32 values; further values of the set are
// discarded and every beat of that set then has overflow set
// after the closing beat in_ch.ready falls and out_ch sends the set in
// ascending order from the head cell, one beat per cycle while out_ch.ready
// is high, the final beat marked last_res. the first result is offered the
// cycle after the closing beat; the drain of the row through its head cell
// sets the output pace
// a stall on out_ch simply holds the head value; in_ch reopens the cycle
// after the last beat is taken
// reset clears the fill count and the overflow flag and opens in_ch; the
// row contents need no clearing
module insertion_sorter (
  input  logic              clk_i,
  input  logic              rst_ni,
  isort_in_if.sink          in_ch,
  isort_out_if.source       out_ch
);
  import isort_pkg::*;

  cmd_t cmd;  // beat-level commands for the row
  sts_t sts;  // fill status of the row

  // sequencing: collect / drain
  isort_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_last_i   (in_ch.data.last),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // cell row, fill count and overflow flag
  isort_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_ch.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_ch.data)
  );

endmodule

// File: tb/tb_insertion_sorter.sv
`timescale 1ns / 1ps

module tb_insertion_sorter;
  import isort_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 100000;
  // cycles the receiver refuses beats during the back-pressure phase
  localparam int unsigned HOLD_CYCLES = 300;
  // idle chance per cycle, in percent, on either side
  localparam int unsigned IDLE_PCT    = 36;
  // beats pushed before the random sets stop
  localparam int unsigned ITEM_TARGET = 150;

  logic clk;
  logic rst_n;

  isort_in_if  in_bus ();
  isort_out_if out_bus ();

  insertion_sorter DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_bus.sink),
    .out_ch (out_bus.source)
  );

  // beats waiting to be offered; the head is the one on in_bus while valid is high
  in_item_t  feed_q[$];
  // results the sorter still owes, oldest first
  out_item_t sorted_out_q[$];

  // shadow of the sorting row: values held in ascending order
  logic signed [VAL_W-1:0] row_vals[$];
  bit                      row_lost;

  int unsigned cycles;
  int unsigned err_cnt;
  int unsigned pushed;
  int unsigned hold_left;
  bit          hold_req;
  bit          no_idle;
  bit          beat_taken;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // place one accepted value into the shadow row; a closing beat flushes the row
  // into the expected results
  task automatic place_value(input in_item_t beat);
    logic signed [VAL_W-1:0] v;
    int                      pos;
    out_item_t               res;
    v = beat.value;
    if (row_vals.size() >= MAX_ITEMS) begin
      // row full: value discarded, whole set flagged
      row_lost = 1'b1;
    end else begin
      // stable: goes behind every stored value equal to or smaller than it
      pos = row_vals.size();
      while (pos > 0 && row_vals[pos-1] > v) pos--;
      row_vals.insert(pos, v);
    end
    if (beat.last) begin
      foreach (row_vals[k]) begin
        res.value_res = row_vals[k];
        res.last_res  = (k == row_vals.size() - 1);
        res.overflow  = row_lost;
        sorted_out_q  = {sorted_out_q, res};
      end
      row_vals.delete();
      row_lost = 1'b0;
    end
  endtask

  task automatic push_item(input logic signed [VAL_W-1:0] v, input bit l);
    in_item_t it;
    it.value = v;
    it.last  = l;
    feed_q   = {feed_q, it};
    pushed++;
  endtask

  // one whole set of n values; narrow sets crowd values together so ties are common
  task automatic add_set(input int n, input bit narrow);
    logic signed [VAL_W-1:0] v;
    for (int i = 0; i < n; i++) begin
      if (narrow) begin
        v = $signed($urandom_range(0, 6)) - 3;
      end else begin
        case ($urandom_range(0, 9))
          0:       v = 32'sh8000_0000;
          1:       v = 32'sh7fff_ffff;
          2, 3:    v = $signed($urandom_range(0, 4)) - 2;
          default: v = $urandom;
        endcase
      end
      push_item(v, i == n - 1);
    end
  endtask

  // sender pause: nothing left to offer, every expected beat back, no hold-off left
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (feed_q.size() != 0 || sorted_out_q.size() != 0 || hold_left != 0);
  endtask

  // input driver: a beat on offer stays put until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else if (!in_bus.valid || beat_taken) begin
      beat_taken = 1'b0;
      if (feed_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_bus.valid <= 1'b1;
        in_bus.data  <= feed_q[0];
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // monitor: predict on every input beat, check every output beat
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    cycles++;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        place_value(in_bus.data);
        feed_q.delete(0);
        beat_taken = 1'b1;
      end
      if (out_bus.valid && out_bus.ready) begin
        got = out_bus.data;
        if (sorted_out_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result beat: value %0d last %0b overflow %0b",
                     got.value_res, got.last_res, got.overflow);
        end else begin
          want = sorted_out_q.pop_front();
          if (got.value_res !== want.value_res || got.last_res !== want.last_res ||
              got.overflow !== want.overflow) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"mismatch: expected value %0d last %0b overflow %0b, ",
                        "got value %0d last %0b overflow %0b"},
                       want.value_res, want.last_res, want.overflow,
                       got.value_res, got.last_res, got.overflow);
          end
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_insertion_sorter: errors");
      $finish;
    end
  end

  initial begin
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
    rst_n         = 1'b0;
    cycles        = 0;
    err_cnt       = 0;
    pushed        = 0;
    hold_left     = 0;
    hold_req      = 1'b0;
    no_idle       = 1'b0;
    beat_taken    = 1'b0;
    row_lost      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // extremes of the value range, zero and minus one, ties, then the close
    push_item(32'sh7fff_ffff, 1'b0);
    push_item(32'sh8000_0000, 1'b0);
    push_item(0, 1'b0);
    push_item(-1, 1'b0);
    push_item(1, 1'b0);
    push_item(5, 1'b0);
    push_item(5, 1'b0);
    push_item(-5, 1'b0);
    push_item(5, 1'b1);
    // single-value sets at both ends of the range
    push_item(32'sh8000_0000, 1'b1);
    push_item(32'sh7fff_ffff, 1'b1);
    // two equal values
    push_item(-1, 1'b0);
    push_item(-1, 1'b1);
    wait_drained();

    // exactly full row, then a set that overruns it and closes on a dropped value
    add_set(MAX_ITEMS, 1'b0);
    add_set(MAX_ITEMS + 2, 1'b0);
    wait_drained();

    // receiver holds off while several sets are offered, so in_ch backs up
    hold_req = 1'b1;
    add_set(6, 1'b0);
    add_set(12, 1'b1);
    add_set(3, 1'b0);
    wait_drained();

    // stretch with no idling on either side, back-to-back sets
    no_idle = 1'b1;
    while (pushed < 120) add_set($urandom_range(1, 8), $urandom_range(0, 3) == 0);
    wait_drained();
    no_idle = 1'b0;

    // random sets, mostly short, now and then an overrun
    while (pushed < ITEM_TARGET) begin
      if ($urandom_range(0, 15) == 0)
        add_set($urandom_range(MAX_ITEMS - 1, MAX_ITEMS + 4), 1'b0);
      else
        add_set($urandom_range(1, 10), $urandom_range(0, 7) == 0);
    end
    wait_drained();

    // let any stray beat show up before the verdict
    repeat (2 * MAX_ITEMS + 8) @(posedge clk);
    #1;
    if (sorted_out_q.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("tb_insertion_sorter: clean");
    end else begin
      $display("tb_insertion_sorter: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/isort_pkg.sv
sv/isort_in_if.sv
sv/isort_out_if.sv
sv/isort_ctrl.sv
sv/isort_dp.sv
sv/insertion_sorter.sv
tb/tb_insertion_sorter.sv
